/* sv/assert_macros.svh */
// Assertion helpers shared by the table core.
// The clocked forms assume a signal named clk, and KRT_ASSERT also rst_n, in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define KRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define KRT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

/* sv/krt_pkg.sv */
// ----------------------------------------------------------------------------
// krt_pkg
// Shared types and constants of the keyed record table: request codes,
// status codes and the stored record layout.
// ----------------------------------------------------------------------------
package krt_pkg;

  localparam int unsigned DEFAULT_TABLE_DEPTH = 128;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned QTY_W    = 32;
  localparam int unsigned PRICE_W  = 32;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned FILL_W   = 8;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND = 3'd0,
    FN_FIND   = 3'd1,
    FN_UPDATE = 3'd2,
    FN_DELETE = 3'd3,
    FN_READ   = 3'd4
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BEYOND    = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [KEY_W-1:0]   key;
    logic signed [QTY_W-1:0]   quantity;
    logic        [PRICE_W-1:0] price;
  } record_t;

  localparam int unsigned RECORD_W = $bits(record_t);

endpackage

/* sv/krt_if.sv */
// ----------------------------------------------------------------------------
// krt_req_if / krt_rsp_if
// Valid/ready channels for request beats and result beats of the table.
// ----------------------------------------------------------------------------
interface krt_req_if;
  import krt_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic signed [KEY_W-1:0]   record_key;
  logic signed [QTY_W-1:0]   new_quantity;
  logic [PRICE_W-1:0]        new_price;
  logic [POS_W-1:0]          read_position;

  modport source (output valid, func, record_key, new_quantity, new_price, read_position,
                  input ready);
  modport sink   (input valid, func, record_key, new_quantity, new_price, read_position,
                  output ready);
endinterface

interface krt_rsp_if;
  import krt_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [KEY_W-1:0]   found_key;
  logic signed [QTY_W-1:0]   found_quantity;
  logic [PRICE_W-1:0]        found_price;
  logic [POS_W-1:0]          hit_position;
  logic [FILL_W-1:0]         fill_after;

  modport source (output valid, status, found_key, found_quantity, found_price,
                  hit_position, fill_after, input ready);
  modport sink   (input valid, status, found_key, found_quantity, found_price,
                  hit_position, fill_after, output ready);
endinterface

/* sv/keyed_record_table_core.sv */
// Append and unused codes go straight to S_FINISH; read passes through S_READ first.
// Find and update scan from position 0 to the first hit (one entry compared per cycle).
// Delete scans the same way, then moves later records down one per cycle through the
// single memory port pair and at the end lowers the fill count by one.
// One request at a time: in_ch.ready returns in the same cycle the result beat is offered.
// Reset (synchronous, active low) clears state, fill count, ptr_r, pend_r and handshakes.
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// keyed_record_table_core
// Packed table of key/quantity/price records with append, find, update,
// delete-with-compaction and read-by-position, run by a small sequencer
// around one record memory and one key comparator.
// ----------------------------------------------------------------------------
module keyed_record_table_core #(
  parameter int unsigned TABLE_DEPTH = krt_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  krt_req_if.sink   in_ch,
  krt_rsp_if.source out_ch
);
  import krt_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_READ   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  // Control registers.
  state_t           state_r,     state_nxt;
  logic [CNT_W-1:0] fill_r,      fill_nxt;
  logic [CNT_W-1:0] ptr_r,       ptr_nxt;
  logic             pend_r,      pend_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [IDX_W-1:0] cmp_r,        cmp_nxt;
  func_t            op_r,         op_nxt;
  logic [KEY_W-1:0] key_r,        key_nxt;
  logic [QTY_W-1:0] qty_r,        qty_nxt;
  logic [PRICE_W-1:0] price_r,    price_nxt;
  status_t          res_status_r, res_status_nxt;
  record_t          res_rec_r,    res_rec_nxt;
  logic [IDX_W-1:0] res_pos_r,    res_pos_nxt;
  status_t          out_status_r, out_status_nxt;
  record_t          out_rec_r,    out_rec_nxt;
  logic [POS_W-1:0] out_pos_r,    out_pos_nxt;
  logic [FILL_W-1:0] out_fill_r,  out_fill_nxt;

  // Memory port.
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  record_t          rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  record_t          wr_data;

  logic  accept;
  logic  walk_rd;
  logic  key_match;
  logic  rpos_ok;
  func_t req_func;

  krt_store #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (RECORD_W)
  ) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && (state_r == S_IDLE);
  assign req_func    = func_t'(in_ch.func);
  assign rpos_ok     = CMP_W'(in_ch.read_position) < CMP_W'(fill_r);

  // During a scan or a shift one entry is read per cycle; rd_data then holds
  // the entry at cmp_r whenever pend_r is set.
  assign walk_rd   = ptr_r < fill_r;
  assign key_match = pend_r && (rd_data.key == key_r);

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    ptr_nxt        = ptr_r;
    pend_nxt       = pend_r;
    cmp_nxt        = cmp_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    qty_nxt        = qty_r;
    price_nxt      = price_r;
    res_status_nxt = res_status_r;
    res_rec_nxt    = res_rec_r;
    res_pos_nxt    = res_pos_r;
    out_status_nxt = out_status_r;
    out_rec_nxt    = out_rec_r;
    out_pos_nxt    = out_pos_r;
    out_fill_nxt   = out_fill_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    rd_en          = 1'b0;
    rd_addr        = IDX_W'(ptr_r);
    wr_en          = 1'b0;
    wr_addr        = cmp_r;
    wr_data        = rd_data;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt         = req_func;
          key_nxt        = in_ch.record_key;
          qty_nxt        = in_ch.new_quantity;
          price_nxt      = in_ch.new_price;
          res_status_nxt = ST_OK;
          res_rec_nxt    = '0;
          res_pos_nxt    = '0;
          state_nxt      = S_FINISH;
          case (req_func)
            FN_APPEND: begin
              if (fill_r == DEPTH_C) begin
                res_status_nxt = ST_FULL;
              end else begin
                wr_en       = 1'b1;
                wr_addr     = IDX_W'(fill_r);
                wr_data     = '{key: in_ch.record_key, quantity: in_ch.new_quantity,
                                price: in_ch.new_price};
                res_rec_nxt = wr_data;
                res_pos_nxt = IDX_W'(fill_r);
                fill_nxt    = fill_r + CNT_W'(1);
              end
            end
            FN_FIND, FN_UPDATE, FN_DELETE: begin
              if (fill_r == '0) begin
                res_status_nxt = ST_NOT_FOUND;
              end else begin
                ptr_nxt   = '0;
                pend_nxt  = 1'b0;
                state_nxt = S_SCAN;
              end
            end
            FN_READ: begin
              if (rpos_ok) begin
                rd_en       = 1'b1;
                rd_addr     = IDX_W'(in_ch.read_position);
                res_pos_nxt = IDX_W'(in_ch.read_position);
                state_nxt   = S_READ;
              end else begin
                res_status_nxt = ST_BEYOND;
              end
            end
            default: begin
              res_status_nxt = ST_OK;
            end
          endcase
        end
      end

      S_SCAN: begin
        rd_en    = walk_rd;
        ptr_nxt  = ptr_r + CNT_W'(walk_rd);
        pend_nxt = walk_rd;
        if (walk_rd) begin
          cmp_nxt = IDX_W'(ptr_r);
        end
        if (key_match) begin
          res_status_nxt = ST_OK;
          res_pos_nxt    = cmp_r;
          res_rec_nxt    = rd_data;
          case (op_r)
            FN_UPDATE: begin
              wr_en       = 1'b1;
              wr_addr     = cmp_r;
              wr_data     = '{key: rd_data.key, quantity: qty_r, price: price_r};
              res_rec_nxt = wr_data;
              state_nxt   = S_FINISH;
            end
            FN_DELETE: begin
              // The read just issued fetches the entry after the hit, which
              // is the first one to move down.
              state_nxt = S_SHIFT;
            end
            default: begin
              state_nxt = S_FINISH;
            end
          endcase
        end else if (pend_r && !walk_rd) begin
          res_status_nxt = ST_NOT_FOUND;
          res_rec_nxt    = '0;
          res_pos_nxt    = '0;
          state_nxt      = S_FINISH;
        end
      end

      S_SHIFT: begin
        rd_en    = walk_rd;
        ptr_nxt  = ptr_r + CNT_W'(walk_rd);
        pend_nxt = walk_rd;
        if (walk_rd) begin
          cmp_nxt = IDX_W'(ptr_r);
        end
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = cmp_r - IDX_W'(1);
          wr_data = rd_data;
        end
        if (!walk_rd) begin
          fill_nxt  = fill_r - CNT_W'(1);
          state_nxt = S_FINISH;
        end
      end

      S_READ: begin
        res_rec_nxt = rd_data;
        state_nxt   = S_FINISH;
      end

      S_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_rec_nxt    = res_rec_r;
          out_pos_nxt    = POS_W'(res_pos_r);
          out_fill_nxt   = FILL_W'(fill_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      ptr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      ptr_r       <= ptr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_r        <= cmp_nxt;
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    qty_r        <= qty_nxt;
    price_r      <= price_nxt;
    res_status_r <= res_status_nxt;
    res_rec_r    <= res_rec_nxt;
    res_pos_r    <= res_pos_nxt;
    out_status_r <= out_status_nxt;
    out_rec_r    <= out_rec_nxt;
    out_pos_r    <= out_pos_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.found_key      = out_rec_r.key;
  assign out_ch.found_quantity = out_rec_r.quantity;
  assign out_ch.found_price    = out_rec_r.price;
  assign out_ch.hit_position   = out_pos_r;
  assign out_ch.fill_after     = out_fill_r;

  `KRT_ASSERT(a_fill_bound, fill_r <= DEPTH_C, "fill count exceeds table depth")
  `KRT_ASSERT(a_write_in_range, wr_en |-> (CNT_W'(wr_addr) <= fill_r), "write beyond fill")
  `KRT_ASSERT(a_error_zero, (out_valid_r && out_status_r != ST_OK) |-> (out_rec_r == '0 && out_pos_r == '0), "error beat carries a record")
  `KRT_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (!out_valid_r && state_r == S_IDLE), "reset left the sequencer busy")

endmodule

/* sv/krt_store.sv */
// ----------------------------------------------------------------------------
// krt_store
// Record memory with one write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module krt_store #(
  parameter int unsigned DEPTH  = krt_pkg::DEFAULT_TABLE_DEPTH,
  parameter int unsigned WIDTH  = krt_pkg::RECORD_W,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for keyed_record_table_core. A cycle-free model of the
// record table predicts every result beat, and a monitor compares each result
// beat field by field with the oldest prediction. Directed tests cover the
// empty table, extreme field values, duplicate keys and the full table. A
// random mix then alternates between growing and shrinking the table, with
// bursty requests and a stalling result sink.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import krt_pkg::*;

  localparam int unsigned DEPTH = DEFAULT_TABLE_DEPTH;
  localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 3'd7;
  localparam int RANDOM_ITEMS = 500;
  localparam int TAIL_CYCLES  = 2 * DEPTH + 20;

  typedef struct {
    logic [FUNC_W-1:0]       func;
    logic signed [KEY_W-1:0] key;
    logic signed [QTY_W-1:0] quantity;
    logic [PRICE_W-1:0]      price;
    logic [POS_W-1:0]        position;
  } table_req_t;

  typedef struct {
    status_t                 status;
    logic signed [KEY_W-1:0] key;
    logic signed [QTY_W-1:0] quantity;
    logic [PRICE_W-1:0]      price;
    logic [POS_W-1:0]        position;
    logic [FILL_W-1:0]       fill;
  } table_result_t;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  krt_req_if req_ch ();
  krt_rsp_if rsp_ch ();

  keyed_record_table_core #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (req_ch),
    .out_ch(rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the table, updated when each request beat is accepted.
  record_t       rec_mem [DEPTH];
  int unsigned   rec_count = 0;
  table_result_t pending_results [$];

  int          err_count = 0;
  int          burst_left = 0;
  int          op_count [8];
  int          status_count [4];
  int unsigned stall_cyc = 0;
  stall_mode_t stall_mode = STALL_NONE;

  // A pool of a few keys, so that appends now and then create duplicates.
  logic signed [KEY_W-1:0] key_pool [8];

  function automatic table_result_t table_apply(input table_req_t rq);
    table_result_t res;
    int            hit;
    res.status   = ST_OK;
    res.key      = '0;
    res.quantity = '0;
    res.price    = '0;
    res.position = '0;
    hit = -1;
    case (rq.func)
      FN_APPEND: begin
        if (rec_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          rec_mem[rec_count] = '{key: rq.key, quantity: rq.quantity, price: rq.price};
          res.key      = rq.key;
          res.quantity = rq.quantity;
          res.price    = rq.price;
          res.position = rec_count[POS_W-1:0];
          rec_count++;
        end
      end
      FN_FIND, FN_UPDATE, FN_DELETE: begin
        for (int p = 0; p < rec_count; p++) begin
          if (hit < 0 && rec_mem[p].key == rq.key) hit = p;
        end
        if (hit < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          if (rq.func == FN_UPDATE) begin
            rec_mem[hit].quantity = rq.quantity;
            rec_mem[hit].price    = rq.price;
          end
          res.key      = rec_mem[hit].key;
          res.quantity = rec_mem[hit].quantity;
          res.price    = rec_mem[hit].price;
          res.position = hit[POS_W-1:0];
          if (rq.func == FN_DELETE) begin
            for (int j = hit; j + 1 < rec_count; j++) rec_mem[j] = rec_mem[j+1];
            rec_count--;
          end
        end
      end
      FN_READ: begin
        if (rq.position >= rec_count) begin
          res.status = ST_BEYOND;
        end else begin
          res.key      = rec_mem[rq.position].key;
          res.quantity = rec_mem[rq.position].quantity;
          res.price    = rec_mem[rq.position].price;
          res.position = rq.position;
        end
      end
      default: ;
    endcase
    res.fill = rec_count[FILL_W-1:0];
    return res;
  endfunction

  // The position is taken as a full word and cut to the channel width here.
  function automatic table_req_t make_req(input logic [FUNC_W-1:0] func,
                                          input logic [KEY_W-1:0] key,
                                          input logic [QTY_W-1:0] quantity,
                                          input logic [PRICE_W-1:0] price,
                                          input logic [31:0] position);
    table_req_t rq;
    rq.func     = func;
    rq.key      = key;
    rq.quantity = quantity;
    rq.price    = price;
    rq.position = position[POS_W-1:0];
    return rq;
  endfunction

  // Key of a record held at a random position; random if the table is empty.
  function automatic logic [KEY_W-1:0] held_key();
    if (rec_count == 0) return $urandom;
    return rec_mem[$urandom_range(0, rec_count - 1)].key;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    $display("%0t: mismatch on %s: got 0x%08h, expected 0x%08h", $time, field, got, want);
  endtask

  // Sends one request beat; the sender may idle between bursts of random length.
  task automatic send_req(input table_req_t rq);
    int gap_len;
    if (burst_left == 0) begin
      gap_len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
      if (gap_len > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    req_ch.valid         <= 1'b1;
    req_ch.func          <= rq.func;
    req_ch.record_key    <= rq.key;
    req_ch.new_quantity  <= rq.quantity;
    req_ch.new_price     <= rq.price;
    req_ch.read_position <= rq.position;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_results.push_back(table_apply(rq));
    op_count[rq.func]++;
    burst_left--;
  endtask

  // Holds the sender off until every predicted result beat has come back.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t: result beat with no request waiting", $time);
      end else begin
        table_result_t want;
        want = pending_results.pop_front();
        status_count[want.status]++;
        if (rsp_ch.status !== want.status)
          report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
        if (rsp_ch.found_key !== want.key)
          report_mismatch("found_key", rsp_ch.found_key, want.key);
        if (rsp_ch.found_quantity !== want.quantity)
          report_mismatch("found_quantity", rsp_ch.found_quantity, want.quantity);
        if (rsp_ch.found_price !== want.price)
          report_mismatch("found_price", rsp_ch.found_price, want.price);
        if (rsp_ch.hit_position !== want.position)
          report_mismatch("hit_position", 32'(rsp_ch.hit_position), 32'(want.position));
        if (rsp_ch.fill_after !== want.fill)
          report_mismatch("fill_after", 32'(rsp_ch.fill_after), 32'(want.fill));
      end
    end
  end

  // The result sink picks a new random stall pattern whenever the low byte of stall_cyc is zero.
  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 1;
    if (stall_cyc[7:0] == 8'd0) stall_mode <= stall_mode_t'($urandom_range(0, 2));
    case (stall_mode)
      STALL_NONE:   rsp_ch.ready <= 1'b1;
      STALL_RANDOM: rsp_ch.ready <= ($urandom_range(0, 9) < 6);
      default:      rsp_ch.ready <= (stall_cyc[2:0] < 3'd3);
    endcase
  end

  task automatic test_empty_table();
    send_req(make_req(FN_FIND, $urandom, $urandom, $urandom, $urandom));
    send_req(make_req(FN_UPDATE, $urandom, $urandom, $urandom, $urandom));
    send_req(make_req(FN_DELETE, $urandom, $urandom, $urandom, $urandom));
    send_req(make_req(FN_READ, $urandom, $urandom, $urandom, '0));
    send_req(make_req(FN_READ, $urandom, $urandom, $urandom, '1));
    for (int f = FN_UNUSED_LO; f <= FN_UNUSED_HI; f++)
      send_req(make_req(FUNC_W'(f), $urandom, $urandom, $urandom, $urandom));
  endtask

  task automatic test_extremes_and_duplicates();
    send_req(make_req(FN_APPEND, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, $urandom));
    send_req(make_req(FN_APPEND, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, $urandom));
    send_req(make_req(FN_APPEND, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, $urandom));
    send_req(make_req(FN_APPEND, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, $urandom));
    send_req(make_req(FN_APPEND, 32'h0000_0000, 32'h0000_0005, 32'h0000_0007, $urandom));
    // The first of two equal keys must win for find, update and delete.
    send_req(make_req(FN_FIND, 32'h0000_0000, $urandom, $urandom, $urandom));
    send_req(make_req(FN_UPDATE, 32'h0000_0000, 32'h8000_0000, 32'hffff_ffff, $urandom));
    send_req(make_req(FN_FIND, 32'h7fff_ffff, $urandom, $urandom, $urandom));
    send_req(make_req(FN_DELETE, 32'h0000_0000, $urandom, $urandom, $urandom));
    send_req(make_req(FN_FIND, 32'h0000_0000, $urandom, $urandom, $urandom));
    send_req(make_req(FN_READ, $urandom, $urandom, $urandom, 32'd0));
    send_req(make_req(FN_READ, $urandom, $urandom, $urandom, rec_count - 1));
    send_req(make_req(FN_READ, $urandom, $urandom, $urandom, rec_count));
    send_req(make_req(FN_DELETE, 32'h8000_0000, $urandom, $urandom, $urandom));
    send_req(make_req(FN_DELETE, 32'hffff_ffff, $urandom, $urandom, $urandom));
    send_req(make_req(FN_FIND, 32'h1234_5678, $urandom, $urandom, $urandom));
  endtask

  task automatic test_full_table();
    while (rec_count < DEPTH)
      send_req(make_req(FN_APPEND, $urandom, $urandom, $urandom, $urandom));
    send_req(make_req(FN_APPEND, $urandom, $urandom, $urandom, $urandom));
    send_req(make_req(FN_READ, $urandom, $urandom, $urandom, DEPTH - 1));
    // The last record is the longest search; the first one the longest shift.
    send_req(make_req(FN_FIND, rec_mem[DEPTH-1].key, $urandom, $urandom, $urandom));
    send_req(make_req(FN_UPDATE, rec_mem[DEPTH-1].key, $urandom, $urandom, $urandom));
    send_req(make_req(FN_DELETE, rec_mem[0].key, $urandom, $urandom, $urandom));
    send_req(make_req(FN_READ, $urandom, $urandom, $urandom, DEPTH - 1));
    send_req(make_req(FN_APPEND, $urandom, $urandom, $urandom, $urandom));
    send_req(make_req(FN_APPEND, $urandom, $urandom, $urandom, $urandom));
    while (rec_count > 8)
      send_req(make_req(FN_DELETE, held_key(), $urandom, $urandom, $urandom));
  endtask

  task automatic test_random_mix();
    int                      roll;
    int                      append_pct;
    int                      delete_pct;
    logic [FUNC_W-1:0]       func;
    logic signed [KEY_W-1:0] key;
    logic [31:0]             position;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // Alternate phases that grow the table towards full and shrink it again.
      if ((i / 100) % 2 == 0) begin
        append_pct = 40;
        delete_pct = 10;
      end else begin
        append_pct = 12;
        delete_pct = 38;
      end
      roll = $urandom_range(0, 99);
      if (roll < 4)
        func = FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
      else if (roll < 4 + append_pct)           func = FN_APPEND;
      else if (roll < 4 + append_pct + delete_pct) func = FN_DELETE;
      else if (roll < 70)                       func = FN_FIND;
      else if (roll < 84)                       func = FN_UPDATE;
      else                                      func = FN_READ;

      roll = $urandom_range(0, 99);
      if (func == FN_APPEND)
        key = (roll < 25) ? key_pool[$urandom_range(0, 7)] : (roll < 40) ? held_key() : $urandom;
      else
        key = (roll < 75) ? held_key() : (roll < 85) ? key_pool[$urandom_range(0, 7)] : $urandom;

      if (rec_count != 0 && $urandom_range(0, 9) < 7) position = $urandom_range(0, rec_count - 1);
      else                                            position = $urandom;

      send_req(make_req(func, key, $urandom, $urandom, position));
      if (i == RANDOM_ITEMS / 2) drain_results();
    end
  endtask

  initial begin
    rst_n                = 1'b0;
    req_ch.valid         <= 1'b0;
    req_ch.func          <= '0;
    req_ch.record_key    <= '0;
    req_ch.new_quantity  <= '0;
    req_ch.new_price     <= '0;
    req_ch.read_position <= '0;
    foreach (op_count[i]) op_count[i] = 0;
    foreach (status_count[i]) status_count[i] = 0;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_extremes_and_duplicates();
    test_full_table();
    test_random_mix();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Requests: %0d append, %0d find, %0d update, %0d delete, %0d read, %0d unused.",
             op_count[FN_APPEND], op_count[FN_FIND], op_count[FN_UPDATE],
             op_count[FN_DELETE], op_count[FN_READ],
             op_count[5] + op_count[6] + op_count[7]);
    $display("Results: %0d ok, %0d not found, %0d full, %0d beyond fill; %0d mismatches.",
             status_count[ST_OK], status_count[ST_NOT_FOUND], status_count[ST_FULL],
             status_count[ST_BEYOND], err_count);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("keyed_record_table_core regression: pass");
    end else begin
      $display("keyed_record_table_core regression: fail");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Timed out with %0d results outstanding.", pending_results.size());
    $display("keyed_record_table_core regression: fail");
    $finish;
  end

endmodule
